// ===== hw/rtl/fsgs_pkg.sv =====
// Shared types, codes and defaults for the falling-sand grid step block.
package fsgs_pkg;

    localparam int GRID_COLS_DEFAULT  = 128;
    localparam int GRID_ROWS_DEFAULT  = 64;
    localparam int MAX_GRAINS_DEFAULT = 64;

    // Fixed port widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int COLS_CFG_W = 8;
    localparam int ROWS_CFG_W = 7;
    localparam int CUR_X_W    = 7;
    localparam int CUR_Y_W    = 6;
    localparam int KIND_W     = 3;
    localparam int IDX_OUT_W  = 6;

    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd128;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_SPAWNED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STAYED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MOVED    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_G_ADDR,
        ST_G_LATCH,
        ST_G_EVAL,
        ST_CHK_D,
        ST_CHK_L,
        ST_CHK_R,
        ST_MOVE_CLR,
        ST_MOVE_SET
    } state_t;

    typedef enum logic [2:0] {
        OCC_NONE,
        OCC_RD_DOWN,
        OCC_RD_LEFT,
        OCC_RD_RIGHT,
        OCC_CLEAR_PASS,
        OCC_WR_SPAWN,
        OCC_VACATE,
        OCC_FILL
    } occ_op_t;

    typedef enum logic [1:0] {
        GR_NONE,
        GR_RD,
        GR_WR_SPAWN,
        GR_WR_MOVE
    } gram_op_t;

    typedef enum logic [1:0] {
        DIR_DOWN,
        DIR_LEFT,
        DIR_RIGHT
    } dir_t;

    typedef struct packed {
        logic              capture;
        occ_op_t           occ_op;
        gram_op_t          gram_op;
        logic              latch_xy;
        logic              move_en;
        dir_t              dir;
        logic              idx_clear;
        logic              idx_inc;
        logic              count_inc;
        logic              emit;
        logic [KIND_W-1:0] emit_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_spawn;
        logic spawn_reject;
        logic count_zero;
        logic in_bounds;
        logic occ_full;
        logic last_grain;
    } ctrl_status_t;

endpackage

// ===== hw/rtl/fsgs_ram.sv =====
// Generic single-port RAM with registered read.
module fsgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/fsgs_ctrl.sv =====
// Controller state machine: sequences spawns, ticks and the grid clearing pass.
module fsgs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  fsgs_pkg::ctrl_status_t status,
    output fsgs_pkg::ctrl_cmd_t    cmd,
    output logic                   busy
);

    fsgs_pkg::state_t state_reg;
    fsgs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsgs_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.occ_op    = fsgs_pkg::OCC_NONE;
        cmd.gram_op   = fsgs_pkg::GR_NONE;
        cmd.dir       = fsgs_pkg::DIR_DOWN;
        cmd.emit_kind = fsgs_pkg::KIND_STAYED;
        busy          = 1'b1;

        case (state_reg)
            fsgs_pkg::ST_CLEAR:
            begin
                cmd.occ_op = fsgs_pkg::OCC_CLEAR_PASS;
                if (status.clear_done)
                begin
                    state_next = fsgs_pkg::ST_IDLE;
                end
            end

            fsgs_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = fsgs_pkg::ST_DISPATCH;
                end
            end

            fsgs_pkg::ST_DISPATCH:
            begin
                state_next = fsgs_pkg::ST_IDLE;
                if (status.is_spawn)
                begin
                    cmd.emit = 1'b1;
                    if (status.spawn_reject)
                    begin
                        cmd.emit_kind = fsgs_pkg::KIND_REJECTED;
                    end
                    else
                    begin
                        cmd.emit_kind = fsgs_pkg::KIND_SPAWNED;
                        cmd.occ_op    = fsgs_pkg::OCC_WR_SPAWN;
                        cmd.gram_op   = fsgs_pkg::GR_WR_SPAWN;
                        cmd.count_inc = 1'b1;
                    end
                end
                else if (status.count_zero)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = fsgs_pkg::KIND_EMPTY;
                end
                else
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = fsgs_pkg::ST_G_ADDR;
                end
            end

            fsgs_pkg::ST_G_ADDR:
            begin
                cmd.gram_op = fsgs_pkg::GR_RD;
                state_next  = fsgs_pkg::ST_G_LATCH;
            end

            fsgs_pkg::ST_G_LATCH:
            begin
                cmd.latch_xy = 1'b1;
                state_next   = fsgs_pkg::ST_G_EVAL;
            end

            fsgs_pkg::ST_G_EVAL:
            begin
                if (status.in_bounds)
                begin
                    cmd.occ_op = fsgs_pkg::OCC_RD_DOWN;
                    state_next = fsgs_pkg::ST_CHK_D;
                end
                else
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = fsgs_pkg::KIND_STAYED;
                end
            end

            fsgs_pkg::ST_CHK_D:
            begin
                if (!status.occ_full)
                begin
                    cmd.move_en = 1'b1;
                    cmd.dir     = fsgs_pkg::DIR_DOWN;
                    state_next  = fsgs_pkg::ST_MOVE_CLR;
                end
                else
                begin
                    cmd.occ_op = fsgs_pkg::OCC_RD_LEFT;
                    state_next = fsgs_pkg::ST_CHK_L;
                end
            end

            fsgs_pkg::ST_CHK_L:
            begin
                if (!status.occ_full)
                begin
                    cmd.move_en = 1'b1;
                    cmd.dir     = fsgs_pkg::DIR_LEFT;
                    state_next  = fsgs_pkg::ST_MOVE_CLR;
                end
                else
                begin
                    cmd.occ_op = fsgs_pkg::OCC_RD_RIGHT;
                    state_next = fsgs_pkg::ST_CHK_R;
                end
            end

            fsgs_pkg::ST_CHK_R:
            begin
                if (!status.occ_full)
                begin
                    cmd.move_en = 1'b1;
                    cmd.dir     = fsgs_pkg::DIR_RIGHT;
                    state_next  = fsgs_pkg::ST_MOVE_CLR;
                end
                else
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = fsgs_pkg::KIND_STAYED;
                end
            end

            fsgs_pkg::ST_MOVE_CLR:
            begin
                cmd.occ_op  = fsgs_pkg::OCC_VACATE;
                cmd.gram_op = fsgs_pkg::GR_WR_MOVE;
                state_next  = fsgs_pkg::ST_MOVE_SET;
            end

            fsgs_pkg::ST_MOVE_SET:
            begin
                cmd.occ_op    = fsgs_pkg::OCC_FILL;
                cmd.emit      = 1'b1;
                cmd.emit_kind = fsgs_pkg::KIND_MOVED;
            end

            default:
            begin
                state_next = fsgs_pkg::ST_IDLE;
            end
        endcase

        // after a grain's result: next grain or done
        if (cmd.emit && (cmd.emit_kind inside {fsgs_pkg::KIND_STAYED, fsgs_pkg::KIND_MOVED}))
        begin
            if (status.last_grain)
            begin
                state_next = fsgs_pkg::ST_IDLE;
            end
            else
            begin
                cmd.idx_inc = 1'b1;
                state_next  = fsgs_pkg::ST_G_ADDR;
            end
        end
    end

endmodule

// ===== hw/rtl/fsgs_datapath.sv =====
// Datapath: config registers, grain list and occupancy memories, result registers.
module fsgs_datapath #(
    parameter int GRID_COLS  = fsgs_pkg::GRID_COLS_DEFAULT,
    parameter int GRID_ROWS  = fsgs_pkg::GRID_ROWS_DEFAULT,
    parameter int MAX_GRAINS = fsgs_pkg::MAX_GRAINS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fsgs_pkg::ctrl_cmd_t                 cmd,
    output fsgs_pkg::ctrl_status_t              status,
    input  logic                                cfg_we,
    input  logic [fsgs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsgs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                action,
    input  logic [fsgs_pkg::CUR_X_W-1:0]        cursor_x,
    input  logic [fsgs_pkg::CUR_Y_W-1:0]        cursor_y,
    output logic                                result_valid,
    output logic [fsgs_pkg::KIND_W-1:0]         kind,
    output logic [fsgs_pkg::IDX_OUT_W-1:0]      grain_index,
    output logic [fsgs_pkg::CUR_X_W-1:0]        old_x,
    output logic [fsgs_pkg::CUR_Y_W-1:0]        old_y,
    output logic [fsgs_pkg::CUR_X_W-1:0]        new_x,
    output logic [fsgs_pkg::CUR_Y_W-1:0]        new_y,
    output logic                                last
);

    localparam int XW   = $clog2(GRID_COLS);
    localparam int YW   = $clog2(GRID_ROWS);
    localparam int GW   = (MAX_GRAINS > 1) ? $clog2(MAX_GRAINS) : 1;
    localparam int CNTW = $clog2(MAX_GRAINS + 1);
    localparam int CEW  = ($clog2(GRID_COLS + 1) > fsgs_pkg::COLS_CFG_W) ?
                          $clog2(GRID_COLS + 1) : fsgs_pkg::COLS_CFG_W;
    localparam int REW  = ($clog2(GRID_ROWS + 1) > fsgs_pkg::ROWS_CFG_W) ?
                          $clog2(GRID_ROWS + 1) : fsgs_pkg::ROWS_CFG_W;
    localparam int CXW  = CEW + 1;
    localparam int RXW  = REW + 1;
    localparam int OAW  = XW + YW;
    localparam int OCC_DEPTH = GRID_COLS * (2 ** YW);
    localparam int CYW  = fsgs_pkg::CUR_Y_W + 1;

    // configuration
    logic [fsgs_pkg::COLS_CFG_W-1:0] cols_reg;
    logic [fsgs_pkg::ROWS_CFG_W-1:0] rows_reg;
    logic [CEW-1:0]                  cols_eff;
    logic [REW-1:0]                  rows_eff;

    // control counters
    logic [CNTW-1:0] count_reg;
    logic [GW-1:0]   idx_reg;
    logic [OAW-1:0]  clr_cnt_reg;
    logic            result_valid_reg;

    // captured transaction and grain working registers
    logic                          action_reg;
    logic [fsgs_pkg::CUR_X_W-1:0]  cx_reg;
    logic [CYW-1:0]                cy_reg;
    logic [XW-1:0]                 x_reg;
    logic [YW-1:0]                 y_reg;
    logic [XW-1:0]                 nx_reg;
    logic [YW-1:0]                 ny_reg;

    // result registers
    logic [fsgs_pkg::KIND_W-1:0]    kind_reg;
    logic [fsgs_pkg::IDX_OUT_W-1:0] grain_index_reg;
    logic [fsgs_pkg::CUR_X_W-1:0]   old_x_reg;
    logic [fsgs_pkg::CUR_Y_W-1:0]   old_y_reg;
    logic [fsgs_pkg::CUR_X_W-1:0]   new_x_reg;
    logic [fsgs_pkg::CUR_Y_W-1:0]   new_y_reg;
    logic                           last_reg;

    // memories
    logic           occ_we;
    logic [OAW-1:0] occ_addr;
    logic           occ_wdata;
    logic           occ_rdata;
    logic           gram_we;
    logic [GW-1:0]  gram_addr;
    logic [OAW-1:0] gram_wdata;
    logic [OAW-1:0] gram_rdata;

    logic [YW-1:0]  y_below;

    assign cols_eff = (CEW'(cols_reg) < CEW'(GRID_COLS)) ? CEW'(cols_reg) : CEW'(GRID_COLS);
    assign rows_eff = (REW'(rows_reg) < REW'(GRID_ROWS)) ? REW'(rows_reg) : REW'(GRID_ROWS);
    assign y_below  = y_reg + YW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg         <= fsgs_pkg::COLS_RESET;
            rows_reg         <= fsgs_pkg::ROWS_RESET;
            count_reg        <= '0;
            idx_reg          <= '0;
            clr_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fsgs_pkg::CFG_COLS: cols_reg <= cfg_data;
                    fsgs_pkg::CFG_ROWS: rows_reg <= cfg_data[fsgs_pkg::ROWS_CFG_W-1:0];
                    default:            ;
                endcase
            end
            if (cmd.occ_op == fsgs_pkg::OCC_CLEAR_PASS)
            begin
                clr_cnt_reg <= clr_cnt_reg + OAW'(1);
            end
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + CNTW'(1);
            end
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + GW'(1);
            end
            result_valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            cx_reg     <= cursor_x;
            cy_reg     <= CYW'(cursor_y) + CYW'(1);
        end
        if (cmd.latch_xy)
        begin
            x_reg <= gram_rdata[OAW-1:YW];
            y_reg <= gram_rdata[YW-1:0];
        end
        if (cmd.move_en)
        begin
            ny_reg <= y_below;
            case (cmd.dir)
                fsgs_pkg::DIR_LEFT:  nx_reg <= x_reg - XW'(1);
                fsgs_pkg::DIR_RIGHT: nx_reg <= x_reg + XW'(1);
                default:             nx_reg <= x_reg;
            endcase
        end
        if (cmd.emit)
        begin
            kind_reg <= cmd.emit_kind;
            case (cmd.emit_kind)
                fsgs_pkg::KIND_SPAWNED:
                begin
                    grain_index_reg <= fsgs_pkg::IDX_OUT_W'(count_reg);
                    old_x_reg       <= cx_reg;
                    old_y_reg       <= fsgs_pkg::CUR_Y_W'(cy_reg);
                    new_x_reg       <= cx_reg;
                    new_y_reg       <= fsgs_pkg::CUR_Y_W'(cy_reg);
                    last_reg        <= 1'b1;
                end
                fsgs_pkg::KIND_STAYED:
                begin
                    grain_index_reg <= fsgs_pkg::IDX_OUT_W'(idx_reg);
                    old_x_reg       <= fsgs_pkg::CUR_X_W'(x_reg);
                    old_y_reg       <= fsgs_pkg::CUR_Y_W'(y_reg);
                    new_x_reg       <= fsgs_pkg::CUR_X_W'(x_reg);
                    new_y_reg       <= fsgs_pkg::CUR_Y_W'(y_reg);
                    last_reg        <= status.last_grain;
                end
                fsgs_pkg::KIND_MOVED:
                begin
                    grain_index_reg <= fsgs_pkg::IDX_OUT_W'(idx_reg);
                    old_x_reg       <= fsgs_pkg::CUR_X_W'(x_reg);
                    old_y_reg       <= fsgs_pkg::CUR_Y_W'(y_reg);
                    new_x_reg       <= fsgs_pkg::CUR_X_W'(nx_reg);
                    new_y_reg       <= fsgs_pkg::CUR_Y_W'(ny_reg);
                    last_reg        <= status.last_grain;
                end
                default:
                begin
                    grain_index_reg <= '0;
                    old_x_reg       <= '0;
                    old_y_reg       <= '0;
                    new_x_reg       <= '0;
                    new_y_reg       <= '0;
                    last_reg        <= 1'b1;
                end
            endcase
        end
    end

    // occupancy port: cell (x, y) lives at {x, y}
    always_comb
    begin
        occ_we    = 1'b0;
        occ_wdata = 1'b0;
        occ_addr  = {x_reg, y_reg};
        case (cmd.occ_op)
            fsgs_pkg::OCC_RD_DOWN:  occ_addr = {x_reg, y_below};
            fsgs_pkg::OCC_RD_LEFT:  occ_addr = {x_reg - XW'(1), y_below};
            fsgs_pkg::OCC_RD_RIGHT: occ_addr = {x_reg + XW'(1), y_below};
            fsgs_pkg::OCC_CLEAR_PASS:
            begin
                occ_addr = clr_cnt_reg;
                occ_we   = 1'b1;
            end
            fsgs_pkg::OCC_WR_SPAWN:
            begin
                occ_addr  = {XW'(cx_reg), YW'(cy_reg)};
                occ_we    = 1'b1;
                occ_wdata = 1'b1;
            end
            fsgs_pkg::OCC_VACATE:
            begin
                occ_we = 1'b1;
            end
            fsgs_pkg::OCC_FILL:
            begin
                occ_addr  = {nx_reg, ny_reg};
                occ_we    = 1'b1;
                occ_wdata = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        gram_we    = 1'b0;
        gram_addr  = idx_reg;
        gram_wdata = {nx_reg, ny_reg};
        case (cmd.gram_op)
            fsgs_pkg::GR_WR_SPAWN:
            begin
                gram_we    = 1'b1;
                gram_addr  = GW'(count_reg);
                gram_wdata = {XW'(cx_reg), YW'(cy_reg)};
            end
            fsgs_pkg::GR_WR_MOVE:
            begin
                gram_we = 1'b1;
            end
            default: ;
        endcase
    end

    fsgs_ram #(
        .WIDTH (1),
        .DEPTH (OCC_DEPTH)
    ) u_occ_ram (
        .clk   (clk),
        .we    (occ_we),
        .addr  (occ_addr),
        .wdata (occ_wdata),
        .rdata (occ_rdata)
    );

    fsgs_ram #(
        .WIDTH (OAW),
        .DEPTH (MAX_GRAINS)
    ) u_grain_ram (
        .clk   (clk),
        .we    (gram_we),
        .addr  (gram_addr),
        .wdata (gram_wdata),
        .rdata (gram_rdata)
    );

    always_comb
    begin
        status.clear_done   = (clr_cnt_reg == OAW'(OCC_DEPTH - 1));
        status.is_spawn     = action_reg;
        status.spawn_reject = (count_reg == CNTW'(MAX_GRAINS)) ||
                              (CEW'(cx_reg) >= cols_eff) ||
                              (REW'(cy_reg) >= rows_eff);
        status.count_zero   = (count_reg == '0);
        // all four neighbours inside the columns and rows in effect
        status.in_bounds    = (x_reg != '0) && (y_reg != '0) &&
                              (CXW'(x_reg) + CXW'(2) <= CXW'(cols_eff)) &&
                              (RXW'(y_reg) + RXW'(2) <= RXW'(rows_eff));
        status.occ_full     = occ_rdata;
        status.last_grain   = (CNTW'(idx_reg) + CNTW'(1) == count_reg);
    end

    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign grain_index  = grain_index_reg;
    assign old_x        = old_x_reg;
    assign old_y        = old_y_reg;
    assign new_x        = new_x_reg;
    assign new_y        = new_y_reg;
    assign last         = last_reg;

endmodule

// ===== hw/rtl/falling_sand_grid_step.sv =====
// Top level of the falling-sand grid step block.
//
//   channel   | handshake                    | payload
//   ----------+------------------------------+------------------------------------------
//   command   | start, busy (start && !busy) | action, cursor_x, cursor_y
//   config    | cfg_valid, cfg_ready         | cfg_index, cfg_data
//   result    | result_valid (one cycle)     | kind, grain_index, old_x, old_y,
//             |                              | new_x, new_y, last
//
// A spawn or an empty tick is decided in the dispatch state; its result strobe is registered.
// A tick handles its grains one at a time, each with a serial grain-list read
// and up to three occupancy reads and two writes through one memory port.
// After reset all GRID_COLS times 2**clog2(GRID_ROWS) occupancy cells (8192 by default)
// are cleared, one cell a cycle; busy stays high meanwhile.
// Results cannot be stalled; cfg_ready is always high.
module falling_sand_grid_step #(
    parameter int GRID_COLS  = fsgs_pkg::GRID_COLS_DEFAULT,
    parameter int GRID_ROWS  = fsgs_pkg::GRID_ROWS_DEFAULT,
    parameter int MAX_GRAINS = fsgs_pkg::MAX_GRAINS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            action,
    input  logic [fsgs_pkg::CUR_X_W-1:0]    cursor_x,
    input  logic [fsgs_pkg::CUR_Y_W-1:0]    cursor_y,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fsgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsgs_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            result_valid,
    output logic [fsgs_pkg::KIND_W-1:0]     kind,
    output logic [fsgs_pkg::IDX_OUT_W-1:0]  grain_index,
    output logic [fsgs_pkg::CUR_X_W-1:0]    old_x,
    output logic [fsgs_pkg::CUR_Y_W-1:0]    old_y,
    output logic [fsgs_pkg::CUR_X_W-1:0]    new_x,
    output logic [fsgs_pkg::CUR_Y_W-1:0]    new_y,
    output logic                            last
);

    fsgs_pkg::ctrl_cmd_t    cmd;
    fsgs_pkg::ctrl_status_t status;

    assign cfg_ready = 1'b1;

    fsgs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    fsgs_datapath #(
        .GRID_COLS  (GRID_COLS),
        .GRID_ROWS  (GRID_ROWS),
        .MAX_GRAINS (MAX_GRAINS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .result_valid (result_valid),
        .kind         (kind),
        .grain_index  (grain_index),
        .old_x        (old_x),
        .old_y        (old_y),
        .new_x        (new_x),
        .new_y        (new_y),
        .last         (last)
    );

`ifndef SYNTHESIS
    // every result comes out of work in progress
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    // more results pending means the block is still working
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("non-final result while idle");

    // an idle cycle is never followed straight away by a result
    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !result_valid)
        else $error("result strobe right after an idle cycle");

    // spawn, reject and empty tick give exactly one result
    a_single_results_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind == fsgs_pkg::KIND_SPAWNED ||
                          kind == fsgs_pkg::KIND_REJECTED ||
                          kind == fsgs_pkg::KIND_EMPTY)) |-> last)
        else $error("single-result transaction without last");
`endif

endmodule
